@@ rtl/rsv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsv_pkg
// Types and constants shared by the record stream validator modules.
// ----------------------------------------------------------------------------
package rsv_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Field widths of the result
  localparam int unsigned LINE_W   = 3;
  localparam int unsigned REC_W    = 16;
  localparam int unsigned SLOT_W   = 24;
  localparam int unsigned TDATA_W  = 64;
  localparam int unsigned RESULT_W = 58;

  // Byte class, decided at the front
  typedef enum logic [2:0] {
    KIND_END,
    KIND_LF,
    KIND_CR,
    KIND_TAB,
    KIND_OTHER
  } rsv_kind_t;

  // Verdict codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FEW_LINES = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_TOO_MANY  = 2'd3
  } rsv_status_t;

  // Result word, status in the lowest bits
  typedef struct packed {
    logic [REC_W-1:0]  fail_record;
    logic [SLOT_W-1:0] slot_total;
    logic [REC_W-1:0]  record_count;
    rsv_status_t       status;
  } rsv_result_t;

endpackage : rsv_pkg
`default_nettype wire

@@ rtl/record_stream_validator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// record_stream_validator
// Checks a zero-terminated text buffer of eight-line records and reports one
// verdict per buffer.
// ----------------------------------------------------------------------------
// Bytes stream in on s_axis at one per clock with no bubbles while nothing
// stalls; each byte needs only small counter updates in the back stage. A
// byte passes the input register, a two-entry queue and the checker; when
// the checker takes the zero byte, the verdict for the buffer is loaded into
// an output register that drives m_axis. The input keeps flowing while the
// verdict waits, until a second zero byte reaches the checker with the first
// verdict still untaken, which stalls the checker and, once the queue fills,
// the input. max_args is written through cfg_wr_en / cfg_wr_data, by the user
// only between buffers (the block does not enforce this), and resets to 64.
module record_stream_validator #(
  parameter int unsigned LINES_PER_RECORD = 8,
  parameter int unsigned COUNT_BITS       = 16,
  parameter int unsigned SLOT_BITS        = 24
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata    // [1:0] status, [17:2] record_count,
                                 // [41:18] slot_total, [57:42] fail_record
);
  import rsv_pkg::*;

  logic        fq_valid;
  logic        fq_ready;
  rsv_kind_t   fq_kind;
  logic        qb_valid;
  logic        qb_ready;
  rsv_kind_t   qb_kind;
  rsv_result_t result;

  rsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_kind  (fq_kind)
  );

  rsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_kind   (fq_kind),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_kind  (qb_kind)
  );

  rsv_back #(
    .LINES_PER_RECORD (LINES_PER_RECORD),
    .COUNT_BITS       (COUNT_BITS),
    .SLOT_BITS        (SLOT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (qb_valid),
    .in_ready    (qb_ready),
    .in_kind     (qb_kind),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (result)
  );

  // Pad the result word to whole bytes
  assign m_tdata = {(TDATA_W - RESULT_W)'(0), result};

endmodule : record_stream_validator
`default_nettype wire

@@ rtl/rsv_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsv_front
// Accepts buffer bytes and registers the class of each (end, LF, CR, tab,
// other).
// ----------------------------------------------------------------------------
module rsv_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_byte,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rsv_pkg::rsv_kind_t      out_kind
);
  import rsv_pkg::*;

  rsv_kind_t kind_dec;

  // Classify the incoming byte
  always_comb begin
    priority if (in_byte == CH_NUL) begin
      kind_dec = KIND_END;
    end else if (in_byte == CH_LF) begin
      kind_dec = KIND_LF;
    end else if (in_byte == CH_CR) begin
      kind_dec = KIND_CR;
    end else if (in_byte == CH_TAB) begin
      kind_dec = KIND_TAB;
    end else begin
      kind_dec = KIND_OTHER;
    end
  end

  // Take a new word whenever the stage is empty or drains this cycle
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_kind <= kind_dec;
    end
  end

endmodule : rsv_front
`default_nettype wire

@@ rtl/rsv_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsv_queue
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module rsv_queue (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  rsv_pkg::rsv_kind_t      in_kind,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rsv_pkg::rsv_kind_t      out_kind
);
  import rsv_pkg::*;

  localparam int unsigned DEPTH = 2;

  rsv_kind_t   mem [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready  = (count != 2'(DEPTH));
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_kind  = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_kind;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue occupancy above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with occupancy");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> (out_valid && out_kind == $past(in_kind)))
    else $error("word pushed into empty queue not presented");

endmodule : rsv_queue
`default_nettype wire

@@ rtl/rsv_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsv_back
// Runs the record checks on classified bytes, keeps the counters and holds
// the verdict in an output register.
// ----------------------------------------------------------------------------
module rsv_back #(
  parameter int unsigned LINES_PER_RECORD = 8,
  parameter int unsigned COUNT_BITS       = 16,
  parameter int unsigned SLOT_BITS        = 24
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_wr_en,
  input  wire  [7:0]              cfg_wr_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  rsv_pkg::rsv_kind_t      in_kind,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rsv_pkg::rsv_result_t    out_result
);
  import rsv_pkg::*;

  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES_PER_RECORD - 1);

  // Configuration
  logic [7:0]            max_args;

  // Record and buffer state
  logic [LINE_W-1:0]     line_number,      line_number_next;
  logic                  record_started,   record_started_next;
  logic [1:0]            first_line_bytes, first_line_bytes_next;
  logic                  first_byte_is_cr, first_byte_is_cr_next;
  logic [7:0]            arg_count,        arg_count_next;
  logic                  arg_overflow,     arg_overflow_next;
  rsv_status_t           error_code,       error_code_next;
  logic [COUNT_BITS-1:0] records_done,     records_done_next;
  logic [SLOT_BITS-1:0]  slots_done,       slots_done_next;
  logic                  out_valid_next;

  logic                  out_free;
  logic                  pop;
  logic                  pop_end;
  logic [8:0]            rec_slots;
  logic [SLOT_BITS:0]    slot_sum;
  logic                  line_empty;
  rsv_status_t           verdict;
  rsv_result_t           result;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (in_kind != KIND_END) || out_free;
  assign pop      = in_valid && in_ready;
  assign pop_end  = pop && (in_kind == KIND_END);

  assign rec_slots  = {1'b0, arg_count} + 9'd1;
  assign slot_sum   = {1'b0, slots_done} + (SLOT_BITS + 1)'(rec_slots);
  assign line_empty = (first_line_bytes == 2'd0) ||
                      (first_line_bytes == 2'd1 && first_byte_is_cr);

  // Build the verdict for the end of the buffer
  always_comb begin
    verdict = error_code;
    if (error_code == ST_OK && record_started) begin
      verdict = ST_FEW_LINES;
    end
    result.status = verdict;
    if (verdict == ST_OK) begin
      result.record_count = REC_W'(records_done);
      result.slot_total   = SLOT_W'(slots_done);
      result.fail_record  = '0;
    end else begin
      result.record_count = '0;
      result.slot_total   = '0;
      result.fail_record  = REC_W'(records_done);
    end
  end

  // Next state of the checker
  always_comb begin
    line_number_next      = line_number;
    record_started_next   = record_started;
    first_line_bytes_next = first_line_bytes;
    first_byte_is_cr_next = first_byte_is_cr;
    arg_count_next        = arg_count;
    arg_overflow_next     = arg_overflow;
    error_code_next       = error_code;
    records_done_next     = records_done;
    slots_done_next       = slots_done;

    if (pop) begin
      if (in_kind == KIND_END) begin
        // Clear for the next buffer
        line_number_next      = '0;
        record_started_next   = 1'b0;
        first_line_bytes_next = 2'd0;
        first_byte_is_cr_next = 1'b0;
        arg_count_next        = 8'd1;
        arg_overflow_next     = 1'b0;
        error_code_next       = ST_OK;
        records_done_next     = '0;
        slots_done_next       = '0;
      end else if (error_code == ST_OK) begin
        record_started_next = 1'b1;
        if (in_kind == KIND_LF) begin
          // End of line: judge the first line, then advance the line or close the record
          priority if (line_number == '0 && line_empty) begin
            error_code_next = ST_EMPTY;
          end else if (line_number == '0 &&
                       (arg_overflow || arg_count > max_args)) begin
            error_code_next = ST_TOO_MANY;
          end else if (line_number == LAST_LINE) begin
            if (slot_sum[SLOT_BITS] || (&records_done)) begin
              error_code_next = ST_TOO_MANY;
            end else begin
              slots_done_next       = slot_sum[SLOT_BITS-1:0];
              records_done_next     = records_done + COUNT_BITS'(1);
              line_number_next      = '0;
              record_started_next   = 1'b0;
              first_line_bytes_next = 2'd0;
              first_byte_is_cr_next = 1'b0;
              arg_count_next        = 8'd1;
              arg_overflow_next     = 1'b0;
            end
          end else begin
            line_number_next = line_number + LINE_W'(1);
          end
        end else if (line_number == '0) begin
          // Track the first line's length and tabs
          if (first_line_bytes == 2'd0) begin
            first_byte_is_cr_next = (in_kind == KIND_CR);
          end
          if (first_line_bytes != 2'd2) begin
            first_line_bytes_next = first_line_bytes + 2'd1;
          end
          if (in_kind == KIND_TAB) begin
            if (arg_count == 8'hFF) begin
              arg_overflow_next = 1'b1;
            end else begin
              arg_count_next = arg_count + 8'd1;
            end
          end
        end
      end
    end
  end

  // Output register: load on the end word, drop when taken
  always_comb begin
    out_valid_next = out_valid;
    if (pop_end) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // Hold the configured limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_args <= 8'd64;
    end else if (cfg_wr_en) begin
      max_args <= cfg_wr_data;
    end
  end

  // Update checker state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_number      <= '0;
      record_started   <= 1'b0;
      first_line_bytes <= 2'd0;
      first_byte_is_cr <= 1'b0;
      arg_count        <= 8'd1;
      arg_overflow     <= 1'b0;
      error_code       <= ST_OK;
      records_done     <= '0;
      slots_done       <= '0;
      out_valid        <= 1'b0;
    end else begin
      line_number      <= line_number_next;
      record_started   <= record_started_next;
      first_line_bytes <= first_line_bytes_next;
      first_byte_is_cr <= first_byte_is_cr_next;
      arg_count        <= arg_count_next;
      arg_overflow     <= arg_overflow_next;
      error_code       <= error_code_next;
      records_done     <= records_done_next;
      slots_done       <= slots_done_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_end) begin
      out_result <= result;
    end
  end

  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_OK && !pop_end) |=> (error_code == $past(error_code)))
    else $error("latched error changed before end of buffer");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_number <= LAST_LINE)
    else $error("line number beyond record length");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pop_end |=> (error_code == ST_OK && records_done == '0 &&
                 slots_done == '0 && !record_started && out_valid))
    else $error("end of buffer did not clear state and present verdict");

endmodule : rsv_back
`default_nettype wire
